@@ sv/fbk_pkg.sv @@
// shared types, constants and helpers for the face box block
// no dependencies
package fbk_pkg;

    localparam int MAX_GROUP  = 8;
    localparam int PT_W       = 18;
    localparam int SUM_W      = 22;
    localparam int CNT_W      = 4;
    localparam int IDX_W      = 6;
    localparam int SIZE_W     = 13;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CEN_W      = 15;
    localparam int SIDE_W     = 16;
    localparam int AVG_W      = 35;
    localparam int OFS_W      = 38;
    localparam int MAG_W      = 37;
    localparam int ACC_W      = 64;
    localparam int MULB_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_EYE_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOSE_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOUTH_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_MIX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MOUTH_SCALE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EYE_SCALE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd7;

    typedef struct packed {
        logic [CNT_W-1:0]  eye_count;
        logic [CNT_W-1:0]  nose_count;
        logic [CNT_W-1:0]  mouth_count;
        logic [FRAC_W-1:0] center_mix;
        logic [FRAC_W-1:0] mouth_scale;
        logic [FRAC_W-1:0] eye_scale;
        logic [SIZE_W-1:0] image_width;
        logic [SIZE_W-1:0] image_height;
    } cfg_t;

    typedef struct packed {
        logic [SUM_W-1:0] lx;
        logic [SUM_W-1:0] ly;
        logic [SUM_W-1:0] rx;
        logic [SUM_W-1:0] ry;
        logic [SUM_W-1:0] mx;
        logic [SUM_W-1:0] my;
        logic             err;
    } job_t;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                     input logic [CNT_W-1:0] lo);
        if (v < lo)
            return lo;
        if (v > CNT_W'(MAX_GROUP))
            return CNT_W'(MAX_GROUP);
        return v;
    endfunction

endpackage

@@ sv/fbk_front.sv @@
// front end: sorts keypoints into eye and mouth sums, closes a detection
// depends on fbk_pkg
module fbk_front
    import fbk_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  accept,
    input  logic signed [PT_W-1:0] point_x,
    input  logic signed [PT_W-1:0] point_y,
    input  logic                  last_point,
    output logic                  push,
    output job_t                  job
);

    logic [SUM_W-1:0] lx_reg, ly_reg, rx_reg, ry_reg, mx_reg, my_reg;
    logic [SUM_W-1:0] lx_next, ly_next, rx_next, ry_next, mx_next, my_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] e, n, m, two_e, total;
    logic [SUM_W-1:0] px, py;
    logic [IDX_W:0]   run_len;

    always_comb
    begin
        e       = IDX_W'(clamp_count(cfg.eye_count, CNT_W'(1)));
        n       = IDX_W'(clamp_count(cfg.nose_count, CNT_W'(0)));
        m       = IDX_W'(clamp_count(cfg.mouth_count, CNT_W'(1)));
        two_e   = e << 1;
        total   = two_e + n + m;
        px      = SUM_W'(point_x);
        py      = SUM_W'(point_y);
        lx_next = lx_reg;
        ly_next = ly_reg;
        rx_next = rx_reg;
        ry_next = ry_reg;
        mx_next = mx_reg;
        my_next = my_reg;
        priority if (idx_reg < e)
        begin
            lx_next = lx_reg + px;
            ly_next = ly_reg + py;
        end
        else if (idx_reg < two_e)
        begin
            rx_next = rx_reg + px;
            ry_next = ry_reg + py;
        end
        else if (idx_reg >= two_e + n && idx_reg < total)
        begin
            mx_next = mx_reg + px;
            my_next = my_reg + py;
        end
        run_len = {1'b0, idx_reg} + 1'b1;
        push    = accept && last_point;
        job.lx  = lx_next;
        job.ly  = ly_next;
        job.rx  = rx_next;
        job.ry  = ry_next;
        job.mx  = mx_next;
        job.my  = my_next;
        job.err = run_len < {1'b0, total};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lx_reg  <= '0;
            ly_reg  <= '0;
            rx_reg  <= '0;
            ry_reg  <= '0;
            mx_reg  <= '0;
            my_reg  <= '0;
            idx_reg <= '0;
        end
        else if (accept)
        begin
            if (last_point)
            begin
                lx_reg  <= '0;
                ly_reg  <= '0;
                rx_reg  <= '0;
                ry_reg  <= '0;
                mx_reg  <= '0;
                my_reg  <= '0;
                idx_reg <= '0;
            end
            else
            begin
                lx_reg <= lx_next;
                ly_reg <= ly_next;
                rx_reg <= rx_next;
                ry_reg <= ry_next;
                mx_reg <= mx_next;
                my_reg <= my_next;
                if (idx_reg != '1)
                    idx_reg <= idx_reg + 1'b1;
            end
        end
    end

endmodule

@@ sv/fbk_queue.sv @@
// two-entry queue of finished detections between front and back
// depends on fbk_pkg
module fbk_queue
    import fbk_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t job_in,
    input  logic pop,
    output job_t job_out,
    output logic job_valid,
    output logic full
);

    job_t       mem_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] count_reg;

    assign job_out   = mem_reg[rd_reg];
    assign job_valid = count_reg != 2'd0;
    assign full      = count_reg == 2'd2;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= job_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

@@ sv/fbk_back.sv @@
// back end: averages, centre, norms and side for one detection at a time
// shared divider, shift-add multiplier and square root; depends on fbk_pkg
module fbk_back
    import fbk_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    job_valid,
    input  job_t                    job,
    output logic                    pop,
    output logic                    done,
    output logic signed [CEN_W-1:0] center_x,
    output logic signed [CEN_W-1:0] center_y,
    output logic [SIDE_W-1:0]       box_side,
    output logic                    status
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DLOAD = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_MLOAD = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_SQRT  = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;

    localparam logic [2:0] OP_CX   = 3'd0;
    localparam logic [2:0] OP_CY   = 3'd1;
    localparam logic [2:0] OP_MSQX = 3'd2;
    localparam logic [2:0] OP_MSQY = 3'd3;
    localparam logic [2:0] OP_MSC  = 3'd4;
    localparam logic [2:0] OP_ESQX = 3'd5;
    localparam logic [2:0] OP_ESQY = 3'd6;
    localparam logic [2:0] OP_ESC  = 3'd7;

    localparam int DIV_STEPS = AVG_W;
    localparam int NUM_GRP   = 6;

    state_t                  state_reg;
    job_t                    job_reg;
    logic signed [AVG_W-1:0] avg_reg [NUM_GRP];
    logic [2:0]              grp_reg;
    logic [2:0]              op_reg;
    logic [CNT_W-1:0]        dvs_reg;
    logic [CNT_W-1:0]        rem_reg;
    logic [AVG_W-1:0]        quo_reg;
    logic                    neg_reg;
    logic [5:0]              cnt_reg;
    logic [ACC_W-1:0]        acc_reg, mula_reg;
    logic [MULB_W-1:0]       mulb_reg;
    logic [ACC_W-1:0]        sq_reg, sqs_reg, sqr_reg, sqb_reg;
    logic [MULB_W-1:0]       norm_reg;
    logic [ACC_W-1:0]        cxp_reg, cyp_reg, sa_reg, sb_reg;

    logic                    e_first;
    logic [CNT_W-1:0]        e, m;
    logic [SUM_W-1:0]        sum_sel;
    logic [SIZE_W-1:0]       size_sel;
    logic signed [SUM_W+SIZE_W:0] prod;
    logic [CNT_W:0]          trial;
    logic [AVG_W-1:0]        quo_next;
    logic signed [OFS_W-1:0] ex, ey, dx, dy, edx, edy;
    logic [MAG_W-1:0]        adx, ady, aedx, aedy;
    logic [ACC_W-1:0]        mul_a, mul_next;
    logic [MULB_W-1:0]       mul_b;
    logic [ACC_W-1:0]        sq_t, sqs_next, sqr_next;
    logic signed [ACC_W-1:0] cx_full, cy_full;
    logic [ACC_W-1:0]        side_v, side_r;

    function automatic logic [MAG_W-1:0] mag_of(input logic signed [OFS_W-1:0] v);
        logic [OFS_W-1:0] u;
        u = v[OFS_W-1] ? OFS_W'(-v) : OFS_W'(v);
        return u[MAG_W-1:0];
    endfunction

    // half away from zero, 2^-33 pixel down to whole pixels
    function automatic logic [CEN_W-1:0] round_center(input logic signed [ACC_W-1:0] c);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] r;
        mag = c[ACC_W-1] ? ACC_W'(-c) : ACC_W'(c);
        r   = (mag + (ACC_W'(1) << 32)) >> 33;
        if (!c[ACC_W-1])
            return (r > ACC_W'(16383)) ? CEN_W'(16383) : r[CEN_W-1:0];
        if (r > ACC_W'(16384))
            return CEN_W'(16384);
        return (~r[CEN_W-1:0]) + 1'b1;
    endfunction

    always_comb
    begin
        e = clamp_count(cfg.eye_count, CNT_W'(1));
        m = clamp_count(cfg.mouth_count, CNT_W'(1));
        unique case (grp_reg)
            3'd0:    sum_sel = job_reg.lx;
            3'd1:    sum_sel = job_reg.ly;
            3'd2:    sum_sel = job_reg.rx;
            3'd3:    sum_sel = job_reg.ry;
            3'd4:    sum_sel = job_reg.mx;
            default: sum_sel = job_reg.my;
        endcase
        size_sel = grp_reg[0] ? cfg.image_height : cfg.image_width;
        e_first  = grp_reg < 3'd4;
        prod     = $signed(sum_sel) * $signed({1'b0, size_sel});

        // one restoring division step
        trial    = {rem_reg, quo_reg[AVG_W-1]};
        quo_next = {quo_reg[AVG_W-2:0], trial >= {1'b0, dvs_reg}};

        ex   = OFS_W'(avg_reg[0]) + OFS_W'(avg_reg[2]);
        ey   = OFS_W'(avg_reg[1]) + OFS_W'(avg_reg[3]);
        dx   = (OFS_W'(avg_reg[4]) <<< 1) - ex;
        dy   = (OFS_W'(avg_reg[5]) <<< 1) - ey;
        edx  = (OFS_W'(avg_reg[2]) - OFS_W'(avg_reg[0])) <<< 1;
        edy  = (OFS_W'(avg_reg[3]) - OFS_W'(avg_reg[1])) <<< 1;
        adx  = mag_of(dx);
        ady  = mag_of(dy);
        aedx = mag_of(edx);
        aedy = mag_of(edy);

        unique case (op_reg)
            OP_CX:   begin mul_a = ACC_W'(adx); mul_b = MULB_W'(cfg.center_mix); end
            OP_CY:   begin mul_a = ACC_W'(ady); mul_b = MULB_W'(cfg.center_mix); end
            OP_MSQX: begin mul_a = ACC_W'(adx >> 5); mul_b = MULB_W'(adx >> 5); end
            OP_MSQY: begin mul_a = ACC_W'(ady >> 5); mul_b = MULB_W'(ady >> 5); end
            OP_MSC:  begin mul_a = ACC_W'(norm_reg); mul_b = MULB_W'(cfg.mouth_scale); end
            OP_ESQX: begin mul_a = ACC_W'(aedx >> 5); mul_b = MULB_W'(aedx >> 5); end
            OP_ESQY: begin mul_a = ACC_W'(aedy >> 5); mul_b = MULB_W'(aedy >> 5); end
            OP_ESC:  begin mul_a = ACC_W'(norm_reg); mul_b = MULB_W'(cfg.eye_scale); end
        endcase
        mul_next = acc_reg + (mulb_reg[0] ? mula_reg : '0);

        // one digit of the square root
        sq_t = sqr_reg + sqb_reg;
        if (sqs_reg >= sq_t)
        begin
            sqs_next = sqs_reg - sq_t;
            sqr_next = (sqr_reg >> 1) + sqb_reg;
        end
        else
        begin
            sqs_next = sqs_reg;
            sqr_next = sqr_reg >> 1;
        end

        cx_full = (ACC_W'(ex) <<< 16) + (dx[OFS_W-1] ? -$signed(cxp_reg) : $signed(cxp_reg));
        cy_full = (ACC_W'(ey) <<< 16) + (dy[OFS_W-1] ? -$signed(cyp_reg) : $signed(cyp_reg));
        side_v  = (sa_reg > sb_reg) ? sa_reg : sb_reg;
        side_r  = (side_v + (ACC_W'(1) << 23)) >> 24;

        pop = (state_reg == S_IDLE) && job_valid;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                    job_reg <= job;
                grp_reg <= '0;
                op_reg  <= OP_CX;
            end
            S_DLOAD:
            begin
                neg_reg <= prod[SUM_W+SIZE_W];
                quo_reg <= prod[SUM_W+SIZE_W] ? AVG_W'(-prod) : AVG_W'(prod);
                rem_reg <= '0;
                dvs_reg <= e_first ? e : m;
                cnt_reg <= '0;
            end
            S_DIV:
            begin
                rem_reg <= (trial >= {1'b0, dvs_reg}) ? CNT_W'(trial - {1'b0, dvs_reg})
                                                     : trial[CNT_W-1:0];
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 6'(DIV_STEPS - 1))
                begin
                    avg_reg[grp_reg] <= neg_reg ? -$signed(quo_next) : $signed(quo_next);
                    grp_reg          <= grp_reg + 1'b1;
                end
            end
            S_MLOAD:
            begin
                acc_reg  <= '0;
                mula_reg <= mul_a;
                mulb_reg <= mul_b;
                cnt_reg  <= '0;
            end
            S_MUL:
            begin
                acc_reg  <= mul_next;
                mula_reg <= mula_reg << 1;
                mulb_reg <= mulb_reg >> 1;
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == 6'(MULB_W - 1))
                begin
                    unique case (op_reg)
                        OP_CX:   cxp_reg <= mul_next;
                        OP_CY:   cyp_reg <= mul_next;
                        OP_MSQX: sq_reg  <= mul_next;
                        OP_MSQY: sqs_reg <= sq_reg + mul_next;
                        OP_MSC:  sa_reg  <= mul_next;
                        OP_ESQX: sq_reg  <= mul_next;
                        OP_ESQY: sqs_reg <= sq_reg + mul_next;
                        OP_ESC:  sb_reg  <= mul_next;
                    endcase
                    sqr_reg <= '0;
                    sqb_reg <= ACC_W'(1) << 62;
                    if (op_reg != OP_MSQY && op_reg != OP_ESQY && op_reg != OP_ESC)
                        op_reg <= op_reg + 1'b1;
                end
            end
            S_SQRT:
            begin
                sqs_reg <= sqs_next;
                sqr_reg <= sqr_next;
                sqb_reg <= sqb_reg >> 2;
                if (sqb_reg[0])
                begin
                    norm_reg <= sqr_next[MULB_W-1:0];
                    op_reg   <= op_reg + 1'b1;
                end
            end
            S_FIN:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done      <= 1'b0;
            center_x  <= '0;
            center_y  <= '0;
            box_side  <= '0;
            status    <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        if (job.err)
                        begin
                            done     <= 1'b1;
                            center_x <= '0;
                            center_y <= '0;
                            box_side <= '0;
                            status   <= 1'b1;
                        end
                        else
                            state_reg <= S_DLOAD;
                    end
                end
                S_DLOAD:
                    state_reg <= S_DIV;
                S_DIV:
                begin
                    if (cnt_reg == 6'(DIV_STEPS - 1))
                        state_reg <= (grp_reg == 3'(NUM_GRP - 1)) ? S_MLOAD : S_DLOAD;
                end
                S_MLOAD:
                    state_reg <= S_MUL;
                S_MUL:
                begin
                    if (cnt_reg == 6'(MULB_W - 1))
                    begin
                        if (op_reg == OP_ESC)
                            state_reg <= S_FIN;
                        else if (op_reg == OP_MSQY || op_reg == OP_ESQY)
                            state_reg <= S_SQRT;
                        else
                            state_reg <= S_MLOAD;
                    end
                end
                S_SQRT:
                begin
                    if (sqb_reg[0])
                        state_reg <= S_MLOAD;
                end
                S_FIN:
                begin
                    done      <= 1'b1;
                    center_x  <= round_center(cx_full);
                    center_y  <= round_center(cy_full);
                    box_side  <= (side_r > ACC_W'(16'hFFFF)) ? 16'hFFFF
                                                             : side_r[SIDE_W-1:0];
                    status    <= 1'b0;
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status |-> center_x == '0 && center_y == '0 && box_side == '0)
        else $error("error result carries a nonzero payload");

    a_fin_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN |=> done && !status)
        else $error("finished detection gave no ok result");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !job.err |=> state_reg == S_DLOAD)
        else $error("accepted detection did not start the averages");

endmodule

@@ sv/face_box_from_keypoints.sv @@
// face box from keypoints: one keypoint taken per cycle, busy only while the queue is full
// a detection's result is worked out after its last keypoint by the
// bit-serial divider (six averages), shift-add multiplier (eight products) and square root
// two finished detections can wait in the queue while the back end works
// results are strobed by done for one cycle; the receiver cannot stall
// reset clears the sums, the keypoint count and the queue, configuration registers return to defaults
module face_box_from_keypoints
    import fbk_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [PT_W-1:0]  point_x,
    input  logic signed [PT_W-1:0]  point_y,
    input  logic                    last_point,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    output logic                    done,
    output logic signed [CEN_W-1:0] center_x,
    output logic signed [CEN_W-1:0] center_y,
    output logic [SIDE_W-1:0]       box_side,
    output logic                    status
);

    cfg_t cfg_reg;
    logic accept, push, pop, job_valid, full;
    job_t job_in, job_out;

    assign busy   = full;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.eye_count    <= CNT_W'(2);
            cfg_reg.nose_count   <= CNT_W'(0);
            cfg_reg.mouth_count  <= CNT_W'(2);
            cfg_reg.center_mix   <= FRAC_W'(6554);
            cfg_reg.mouth_scale  <= FRAC_W'(14746);
            cfg_reg.eye_scale    <= FRAC_W'(16384);
            cfg_reg.image_width  <= SIZE_W'(640);
            cfg_reg.image_height <= SIZE_W'(480);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_EYE_COUNT:    cfg_reg.eye_count    <= cfg_data[CNT_W-1:0];
                REG_NOSE_COUNT:   cfg_reg.nose_count   <= cfg_data[CNT_W-1:0];
                REG_MOUTH_COUNT:  cfg_reg.mouth_count  <= cfg_data[CNT_W-1:0];
                REG_CENTER_MIX:   cfg_reg.center_mix   <= cfg_data;
                REG_MOUTH_SCALE:  cfg_reg.mouth_scale  <= cfg_data;
                REG_EYE_SCALE:    cfg_reg.eye_scale    <= cfg_data;
                REG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_data[SIZE_W-1:0];
                REG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_data[SIZE_W-1:0];
            endcase
        end
    end

    fbk_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .accept     (accept),
        .point_x    (point_x),
        .point_y    (point_y),
        .last_point (last_point),
        .push       (push),
        .job        (job_in)
    );

    fbk_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .job_in    (job_in),
        .pop       (pop),
        .job_out   (job_out),
        .job_valid (job_valid),
        .full      (full)
    );

    fbk_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (job_valid),
        .job       (job_out),
        .pop       (pop),
        .done      (done),
        .center_x  (center_x),
        .center_y  (center_y),
        .box_side  (box_side),
        .status    (status)
    );

endmodule
